>>> rtl/sfr_pkg.sv
// Package with the shared types and constants of the sum8 frame receiver.
package sfr_pkg;

   localparam int MAX_PAYLOAD = 256;
   localparam int CNT_W       = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;

   localparam logic [7:0] HDR_FIRST  = 8'h55;
   localparam logic [7:0] HDR_SECOND = 8'hAA;
   localparam logic [7:0] HDR_SUM    = 8'(HDR_FIRST + HDR_SECOND);

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_OK       = 2'd1,
      KIND_CSUM_ERR = 2'd2,
      KIND_LEN_ERR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_VERSION = 3'd1,
      PH_COMMAND = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_LEN_LO  = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CHECK   = 3'd6
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [7:0]  byte_index;
      logic [7:0]  version;
      logic [7:0]  command;
      logic [15:0] frame_length;
      logic [7:0]  computed_sum;
   } rsp_payload_type;

   typedef struct packed {
      logic            valid;
      rsp_payload_type payload;
   } result_type;

endpackage

>>> rtl/sfr_if.sv
// Channel interfaces of the sum8 frame receiver: byte requests and result items.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                valid;
   logic                ready;
   sfr_pkg::kind_type   kind;
   logic [7:0]          data;
   logic [7:0]          byte_index;
   logic [7:0]          version;
   logic [7:0]          command;
   logic [15:0]         frame_length;
   logic [7:0]          computed_sum;

   modport source (output valid, output kind, output data, output byte_index,
                   output version, output command, output frame_length,
                   output computed_sum, input ready);
   modport sink   (input valid, input kind, input data, input byte_index,
                   input version, input command, input frame_length,
                   input computed_sum, output ready);
endinterface

>>> rtl/sfr_parser.sv
// Frame parser: header hunt, header fields, payload forwarding and checksum compare.
module sfr_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output sfr_pkg::result_type result
);
   import sfr_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [7:0]         prev_ff, prev_in;
   logic [7:0]         version_ff, version_in;
   logic [7:0]         command_ff, command_in;
   logic [15:0]        length_ff, length_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic [15:0]        count_wide;
   logic [15:0]        count_next;

   assign count_wide = 16'(count_ff);
   assign count_next = count_wide + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      version_in = version_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      result.valid        = 1'b0;
      result.payload.kind = KIND_PAYLOAD;
      result.payload.data = 8'd0;
      result.payload.byte_index = 8'd0;

      unique case (phase_ff)
         PH_VERSION: begin
            version_in = rx_byte;
            sum_in     = sum_ff + rx_byte;
            phase_in   = PH_COMMAND;
         end
         PH_COMMAND: begin
            command_in = rx_byte;
            sum_in     = sum_ff + rx_byte;
            phase_in   = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = {rx_byte, 8'd0};
            sum_in    = sum_ff + rx_byte;
            phase_in  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {length_ff[15:8], rx_byte};
            sum_in    = sum_ff + rx_byte;
            count_in  = '0;
            if (length_in >= 16'(MAX_PAYLOAD)) begin
               result.valid        = 1'b1;
               result.payload.kind = KIND_LEN_ERR;
               prev_in             = 8'd0;
               phase_in            = PH_HUNT;
            end else if (length_in == 16'd0) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in                    = sum_ff + rx_byte;
            result.valid              = 1'b1;
            result.payload.kind       = KIND_PAYLOAD;
            result.payload.data       = rx_byte;
            result.payload.byte_index = count_wide[7:0];
            count_in                  = count_next[CNT_W-1:0];
            if (count_next >= length_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            result.valid        = 1'b1;
            result.payload.kind = (rx_byte == sum_ff) ? KIND_OK : KIND_CSUM_ERR;
            result.payload.data = rx_byte;
            prev_in             = 8'd0;
            phase_in            = PH_HUNT;
         end
         default: begin
            // Header hunt; the unused phase code behaves the same way.
            if (prev_ff == HDR_FIRST && rx_byte == HDR_SECOND) begin
               sum_in   = HDR_SUM;
               phase_in = PH_VERSION;
            end else begin
               phase_in = PH_HUNT;
            end
            prev_in = rx_byte;
         end
      endcase

      result.valid                = result.valid & accept;
      result.payload.version      = version_in;
      result.payload.command      = command_in;
      result.payload.frame_length = length_in;
      result.payload.computed_sum = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         prev_ff    <= 8'd0;
         version_ff <= 8'd0;
         command_ff <= 8'd0;
         length_ff  <= 16'd0;
         count_ff   <= '0;
         sum_ff     <= 8'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         prev_ff    <= prev_in;
         version_ff <= version_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

   // A frame end leaves the block hunting with a cleared previous byte.
   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.payload.kind != KIND_PAYLOAD)
         |=> (phase_ff == PH_HUNT && prev_ff == 8'd0))
      else $error("frame end did not return to header hunt");

   // Payload positions stay below the declared length.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (count_wide < length_ff))
      else $error("payload count reached the declared length");

endmodule

>>> rtl/sfr_out_stage.sv
// Result register with a skid entry, so a byte can be taken while a result waits.
module sfr_out_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  sfr_pkg::result_type      push,
   output logic                     up_ready,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output sfr_pkg::rsp_payload_type dn_payload
);
   import sfr_pkg::*;

   logic            main_valid_ff, skid_valid_ff;
   rsp_payload_type main_ff, skid_ff;
   logic            pop;

   assign up_ready   = !skid_valid_ff;
   assign dn_valid   = main_valid_ff;
   assign dn_payload = main_ff;
   assign pop        = main_valid_ff && dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_ff <= push.valid;
      end else if (push.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (!main_valid_ff || pop) begin
         main_ff <= push.payload;
      end else if (push.valid) begin
         skid_ff <= push.payload;
      end
   end

   // The skid entry only fills behind a waiting result.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid without a result in the main register");

   // The parser never offers a result while the skid entry is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push.valid)
      else $error("result offered while the output stage was full");

endmodule

>>> rtl/sum8_frame_receiver.sv
// Top level of the sum8 frame receiver: byte channel in, frame result channel out.
//
// The block takes one serial byte per transfer on req_bus and hunts for the
// header 0x55 0xAA. It then reads version, command and a big-endian 16-bit
// length, forwards each payload byte as a result transfer with its index, and
// closes the frame with an ok or checksum-error result that carries the
// received checksum byte and the modulo-256 sum of header and payload.
// A declared length of MAX_PAYLOAD or more closes the frame at once with a
// length-error result. The receiver keeps or drops forwarded bytes on the
// final status. Bytes that cause no result (header bytes) give no transfer.
//
// Throughput is one byte per cycle while the skid entry is not full. A result
// is registered in the output register that drives rsp_bus, or in the skid
// entry while an earlier result still waits there.
// When the receiver stalls, the waiting result holds in the output register
// and one more result goes into a skid entry; req_bus.ready drops only while
// that skid entry is full, and rises again in the cycle after rsp_bus takes
// the waiting result, when the skid entry moves into the output register.
// Reset (synchronous, active high) empties both entries, returns the parser
// to header hunt and clears all held header fields and the running sum.
module sum8_frame_receiver (
   input  logic            clock,
   input  logic            reset,
   sfr_req_if.sink         req_bus,
   sfr_rsp_if.source       rsp_bus
);
   import sfr_pkg::*;

   result_type      result;
   rsp_payload_type out_payload;
   logic            stage_ready;
   logic            accept;

   assign req_bus.ready = stage_ready;
   assign accept        = req_bus.valid && stage_ready;

   // Parser updates its state on every accepted byte transfer.
   sfr_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_bus.rx_byte),
      .result  (result)
   );

   // Output register plus skid entry decouple the two channels.
   sfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .push       (result),
      .up_ready   (stage_ready),
      .dn_valid   (rsp_bus.valid),
      .dn_ready   (rsp_bus.ready),
      .dn_payload (out_payload)
   );

   assign rsp_bus.kind         = out_payload.kind;
   assign rsp_bus.data         = out_payload.data;
   assign rsp_bus.byte_index   = out_payload.byte_index;
   assign rsp_bus.version      = out_payload.version;
   assign rsp_bus.command      = out_payload.command;
   assign rsp_bus.frame_length = out_payload.frame_length;
   assign rsp_bus.computed_sum = out_payload.computed_sum;

endmodule

>>> bench/sum8_frame_receiver_test.sv
// Self-checking testbench for the sum8 frame receiver, with its own frame parser model.
`timescale 1ns / 1ps

module sum8_frame_receiver_test;
   import sfr_pkg::*;

   // The longest quiet stretch in a correct run is the receiver hold-off below.
   // Random idling on either side leaves far shorter stretches without a
   // transfer, so this limit only trips on a hang.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 120;
   // A result leaves the block through the output register, or through the skid
   // entry behind it. Extra cycles at the end catch stray results.
   localparam int DRAIN_CYCLES   = 8;

   typedef logic [7:0] byte_queue_type[$];

   logic clock;
   logic reset;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();

   sum8_frame_receiver u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Idling knobs, changed between test phases.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // Long receiver hold-off, run in its own process so the sender keeps offering
   // bytes while the block fills up.
   event hold_off_start;
   logic receiver_held = 1'b0;

   // Results the parser model says the block owes, oldest first.
   rsp_payload_type expected_results[$];

   // Parser model state. It mirrors the block's state after reset.
   logic [7:0]  prev_rx      = 8'h00;
   phase_type   parse_phase  = PH_HUNT;
   logic [7:0]  hdr_version  = 8'h00;
   logic [7:0]  hdr_command  = 8'h00;
   logic [15:0] hdr_length   = 16'h0000;
   logic [15:0] payload_pos  = 16'h0000;
   logic [7:0]  frame_sum    = 8'h00;

   // Bookkeeping for the summary and the verdict.
   int error_count     = 0;
   int bytes_sent      = 0;
   int frames_ok       = 0;
   int frames_bad_sum  = 0;
   int frames_bad_len  = 0;
   int payload_seen    = 0;
   int quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Parser model. It is fed every byte that the block accepts, in order, and
   // queues the result that byte must produce, if any.
   // ------------------------------------------------------------------------

   task automatic close_frame;
      prev_rx     = 8'h00;
      parse_phase = PH_HUNT;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      rsp_payload_type r;
      bit              gives_result;
      gives_result = 1'b0;
      r            = '0;
      case (parse_phase)
         PH_VERSION: begin
            hdr_version = b;
            frame_sum   = frame_sum + b;
            parse_phase = PH_COMMAND;
         end
         PH_COMMAND: begin
            hdr_command = b;
            frame_sum   = frame_sum + b;
            parse_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            hdr_length  = {b, 8'h00};
            frame_sum   = frame_sum + b;
            parse_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            hdr_length[7:0] = b;
            frame_sum       = frame_sum + b;
            payload_pos     = 16'h0000;
            if (hdr_length >= MAX_PAYLOAD) begin
               // Oversized frame: report it and go straight back to hunting.
               r.kind       = KIND_LEN_ERR;
               gives_result = 1'b1;
               close_frame();
            end else if (hdr_length == 16'h0000) begin
               parse_phase = PH_CHECK;
            end else begin
               parse_phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            // The running sum on a payload result already includes that byte.
            frame_sum       = frame_sum + b;
            r.kind          = KIND_PAYLOAD;
            r.data          = b;
            r.byte_index    = payload_pos[7:0];
            gives_result    = 1'b1;
            payload_pos     = payload_pos + 16'd1;
            if (payload_pos >= hdr_length) begin
               parse_phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            r.kind       = (b == frame_sum) ? KIND_OK : KIND_CSUM_ERR;
            r.data       = b;
            gives_result = 1'b1;
            close_frame();
         end
         default: begin
            // Header hunt: a sliding pair of the last two bytes.
            if (prev_rx == HDR_FIRST && b == HDR_SECOND) begin
               frame_sum   = HDR_SUM;
               parse_phase = PH_VERSION;
            end else begin
               parse_phase = PH_HUNT;
            end
            prev_rx = b;
         end
      endcase
      if (gives_result) begin
         r.version      = hdr_version;
         r.command      = hdr_command;
         r.frame_length = hdr_length;
         r.computed_sum = frame_sum;
         expected_results.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------------
   // Byte sender. Inputs change only by nonblocking assignment right after a
   // rising edge. Valid stays high from one byte to the next when there is no
   // idle cycle in between, so it never gets two assignments in one step.
   // ------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      // Signals read right after the edge still hold their pre-edge values, so
      // a high ready here means the byte was taken at this edge.
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_byte(value);
      bytes_sent++;
   endtask

   // Sends a complete frame. The checksum is the true sum plus sum_offset, so a
   // nonzero offset forces a checksum error. An oversized length ends the frame
   // after the header, as the block drops back to hunting there.
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
                             input logic [15:0] len, input byte_queue_type body,
                             input logic [7:0] sum_offset);
      logic [7:0] sum;
      sum = HDR_SUM + ver + cmd + len[15:8] + len[7:0];
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(ver);
      send_byte(cmd);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      if (len < MAX_PAYLOAD) begin
         foreach (body[i]) begin
            send_byte(body[i]);
            sum = sum + body[i];
         end
         send_byte(sum + sum_offset);
      end
   endtask

   function automatic byte_queue_type random_body(input int len);
      byte_queue_type q;
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
      return q;
   endfunction

   // The sender goes quiet until every owed result has been taken.
   task automatic wait_for_drain;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready with random stalls, the long hold-off, and the check of
   // every result transfer against the oldest owed result.
   // ------------------------------------------------------------------------

   initial begin
      forever begin
         @(hold_off_start);
         receiver_held <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         receiver_held <= 1'b0;
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !receiver_held && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t ERROR: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_error($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            report_error($sformatf("result kind %0d data %0h with nothing owed",
                                   rsp_bus.kind, rsp_bus.data));
         end else begin
            want = expected_results.pop_front();
            check_field("kind", 16'(rsp_bus.kind), 16'(want.kind));
            check_field("data", 16'(rsp_bus.data), 16'(want.data));
            check_field("byte_index", 16'(rsp_bus.byte_index), 16'(want.byte_index));
            check_field("version", 16'(rsp_bus.version), 16'(want.version));
            check_field("command", 16'(rsp_bus.command), 16'(want.command));
            check_field("frame_length", rsp_bus.frame_length, want.frame_length);
            check_field("computed_sum", 16'(rsp_bus.computed_sum),
                        16'(want.computed_sum));
         end
         case (rsp_bus.kind)
            KIND_PAYLOAD:  payload_seen++;
            KIND_OK:       frames_ok++;
            KIND_CSUM_ERR: frames_bad_sum++;
            KIND_LEN_ERR:  frames_bad_len++;
            default: ;
         endcase
      end
   end

   // Watchdog: any transfer on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t ERROR: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
         $display("sum8_frame_receiver: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // A zero-length frame goes straight from the length to the checksum. The
   // header bytes are picked so that the good checksum is 0x55; the 0xAA that
   // follows must not be taken as a header, because the frame end clears the
   // previous byte.
   task automatic test_zero_length_resync;
      byte_queue_type none;
      send_frame(8'hFF, 8'h57, 16'h0000, none, 8'h00);
      send_byte(HDR_SECOND);
      wait_for_drain();
   endtask

   // The smallest length that is too long for the block.
   task automatic test_length_error;
      byte_queue_type none;
      send_frame(8'h12, 8'h34, 16'(MAX_PAYLOAD), none, 8'h00);
      wait_for_drain();
   endtask

   // A header pattern inside the payload is plain data. The payload also carries
   // both byte extremes, and the checksum is off by one.
   task automatic test_header_in_payload;
      byte_queue_type body;
      body = '{HDR_FIRST, HDR_SECOND, 8'h00, 8'hFF};
      send_frame(8'h00, 8'hFF, 16'd4, body, 8'h01);
      wait_for_drain();
   endtask

   // Mostly well-formed frames with random content; the rest is line noise rich
   // in header bytes and frames cut off after a few bytes. Only bytes of
   // complete frames count toward the byte budget.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int frame_bytes);
      int          sent;
      int          pick;
      logic [15:0] len;
      logic [7:0]  offset;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent           = 0;
      while (sent < frame_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(0, 9);
               send_byte(pick < 4 ? HDR_FIRST :
                         pick < 6 ? HDR_SECOND : 8'($urandom_range(0, 255)));
            end
         end else if (pick < 12) begin
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               len = 16'($urandom_range(MAX_PAYLOAD, 65535));
            end else if (pick < 7) begin
               len = 16'($urandom_range(MAX_PAYLOAD / 2, MAX_PAYLOAD - 1));
            end else begin
               len = 16'($urandom_range(0, 16));
            end
            offset = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       random_body(len < MAX_PAYLOAD ? int'(len) : 0), offset);
            sent += (len >= MAX_PAYLOAD) ? 6 : 7 + int'(len);
         end
      end
      wait_for_drain();
   endtask

   // The receiver stops taking results for a long stretch while the sender
   // streams a frame without gaps, so both result entries fill and the block
   // must hold off its byte input until the receiver comes back.
   task automatic test_receiver_hold_off;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      -> hold_off_start;
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd40,
                 random_body(40), 8'h00);
      wait_for_drain();
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_zero_length_resync();
      test_length_error();
      test_header_in_payload();
      test_random_traffic(0, 0, 230);
      test_random_traffic(82, 0, 230);
      test_random_traffic(0, 82, 230);
      test_random_traffic(16, 16, 230);
      test_receiver_hold_off();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; saw %0d payload bytes, %0d good frames, %0d bad checksums,",
               bytes_sent, payload_seen, frames_ok, frames_bad_sum);
      $display("%0d oversized frames, under four idling patterns and one long hold-off.",
               frames_bad_len);
      if (error_count == 0) begin
         $display("sum8_frame_receiver: match");
      end else begin
         $display("sum8_frame_receiver: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_parser.sv
rtl/sfr_out_stage.sv
rtl/sum8_frame_receiver.sv
bench/sum8_frame_receiver_test.sv
